// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- hw/rtl/savdf_pkg.sv -----
// ----------------------------------------------------------------------------
// savdf_pkg
// Shared types and constants of the duplicate vertex filter.
// ----------------------------------------------------------------------------
package savdf_pkg;

    localparam int REQ_WIDTH   = 2;
    localparam int ID_WIDTH    = 32;
    localparam int LEVEL_WIDTH = 7;

    typedef enum logic [REQ_WIDTH-1:0] {
        REQ_VERTEX = 2'd0,
        REQ_START  = 2'd1,
        REQ_END    = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

// ----- hw/rtl/savdf_tag_ram.sv -----
// ----------------------------------------------------------------------------
// savdf_tag_ram
// Tag store: one row per set, all ways side by side. One write port, one
// read port, registered read data.
// ----------------------------------------------------------------------------
module savdf_tag_ram #(
    parameter int ADDR_WIDTH = 14,
    parameter int DATA_WIDTH = 576
) (
    input  logic                  aclk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    localparam int DEPTH = 1 << ADDR_WIDTH;

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/savdf_way_match.sv -----
// ----------------------------------------------------------------------------
// savdf_way_match
// Compares a tag against every way of a set row and builds the row with the
// tag placed in the victim way.
// ----------------------------------------------------------------------------
module savdf_way_match #(
    parameter int TAG_WIDTH = 18,
    parameter int NUM_WAYS  = 32,
    parameter int VW        = 5
) (
    input  logic [NUM_WAYS*TAG_WIDTH-1:0] row_in,
    input  logic [TAG_WIDTH-1:0]          tag,
    input  logic [VW-1:0]                 victim,
    output logic                          hit,
    output logic [NUM_WAYS*TAG_WIDTH-1:0] row_out
);

    logic [TAG_WIDTH-1:0] way;

    always_comb begin
        hit     = 1'b0;
        row_out = row_in;
        way     = '0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            way = row_in[w*TAG_WIDTH +: TAG_WIDTH];
            if (way == tag) begin
                hit = 1'b1;
            end
            if (victim == VW'(w)) begin
                row_out[w*TAG_WIDTH +: TAG_WIDTH] = tag;
            end
        end
    end

endmodule

// ----- hw/rtl/set_assoc_duplicate_vertex_filter.sv -----
// ----------------------------------------------------------------------------
// set_assoc_duplicate_vertex_filter
// Drops repeated vertex ids using a set-associative tag store with a global
// round-robin victim pointer.
// ----------------------------------------------------------------------------
//  channel | ports                                   | carries
//  --------+-----------------------------------------+------------------------
//  input   | s_valid s_ready s_req_type s_vertex_id  | vertex / start / end
//          | s_level                                 |
//  output  | m_valid m_ready m_vertex_out m_is_end   | new ids and end marker
//
//  Each request is accepted (set row read issued for a vertex request), then
//  executed (tag compare over all ways, row written back on a miss).
//  After reset and after a start with level 0 the tag store is swept, one
//  set row per cycle over all 2**INDEX_WIDTH rows (16384 by default), no
//  requests accepted meanwhile.
//  A result that finds the output register still full holds the block in
//  execute until m_ready frees it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module set_assoc_duplicate_vertex_filter #(
    parameter int INDEX_WIDTH = 14,
    parameter int TAG_WIDTH   = 18,
    parameter int NUM_WAYS    = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [savdf_pkg::REQ_WIDTH-1:0]     s_req_type,
    input  logic [savdf_pkg::ID_WIDTH-1:0]      s_vertex_id,
    input  logic [savdf_pkg::LEVEL_WIDTH-1:0]   s_level,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [savdf_pkg::ID_WIDTH-1:0]      m_vertex_out,
    output logic                                m_is_end
);

    import savdf_pkg::*;

    localparam int ROW_WIDTH = NUM_WAYS * TAG_WIDTH;
    localparam int VW        = $clog2(NUM_WAYS);

    state_t                   state_reg, state_next;
    logic [INDEX_WIDTH-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [VW-1:0]            victim_reg, victim_next;

    req_type_t                req_type_reg;
    logic [ID_WIDTH-1:0]      vertex_id_reg;
    logic [LEVEL_WIDTH-1:0]   level_reg;

    logic                     out_valid_reg;
    logic [ID_WIDTH-1:0]      out_vertex_reg;
    logic                     out_end_reg;

    logic                     out_free;
    logic                     out_load;
    logic                     out_load_end;

    logic                     rd_en;
    logic                     wr_en;
    logic [INDEX_WIDTH-1:0]   wr_addr;
    logic [ROW_WIDTH-1:0]     wr_data;
    logic [ROW_WIDTH-1:0]     rd_row;
    logic [ROW_WIDTH-1:0]     upd_row;
    logic                     hit;

    logic [2*ID_WIDTH-1:0]    id_ext;
    logic [TAG_WIDTH-1:0]     tag;

    // tag bits past the id's top read as zero
    assign id_ext = {{ID_WIDTH{1'b0}}, vertex_id_reg};
    assign tag    = id_ext[INDEX_WIDTH +: TAG_WIDTH];

    savdf_tag_ram #(
        .ADDR_WIDTH (INDEX_WIDTH),
        .DATA_WIDTH (ROW_WIDTH)
    ) u_tag_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (s_vertex_id[INDEX_WIDTH-1:0]),
        .rd_data (rd_row)
    );

    savdf_way_match #(
        .TAG_WIDTH (TAG_WIDTH),
        .NUM_WAYS  (NUM_WAYS),
        .VW        (VW)
    ) u_way_match (
        .row_in  (rd_row),
        .tag     (tag),
        .victim  (victim_reg),
        .hit     (hit),
        .row_out (upd_row)
    );

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        victim_next  = victim_reg;
        s_ready      = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = vertex_id_reg[INDEX_WIDTH-1:0];
        wr_data      = upd_row;
        out_load     = 1'b0;
        out_load_end = 1'b0;

        case (state_reg)
            ST_CLEAR: begin
                wr_en        = 1'b1;
                wr_addr      = clr_cnt_reg;
                wr_data      = '1;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                rd_en   = s_valid && (s_req_type == REQ_VERTEX);
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (req_type_reg)
                    REQ_VERTEX: begin
                        if (hit) begin
                            state_next = ST_IDLE;
                        end else if (out_free) begin
                            wr_en      = 1'b1;
                            out_load   = 1'b1;
                            state_next = ST_IDLE;
                            if (victim_reg == VW'(NUM_WAYS - 1)) begin
                                victim_next = '0;
                            end else begin
                                victim_next = victim_reg + 1'b1;
                            end
                        end
                    end
                    REQ_START: begin
                        victim_next = '0;
                        if (level_reg == '0) begin
                            clr_cnt_next = '0;
                            state_next   = ST_CLEAR;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    REQ_END: begin
                        if (out_free) begin
                            out_load     = 1'b1;
                            out_load_end = 1'b1;
                            state_next   = ST_IDLE;
                        end
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            victim_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            victim_reg  <= victim_next;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_type_reg  <= req_type_t'(s_req_type);
            vertex_id_reg <= s_vertex_id;
            level_reg     <= s_level;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_vertex_reg <= out_load_end ? '0 : vertex_id_reg;
            out_end_reg    <= out_load_end;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_vertex_out = out_vertex_reg;
    assign m_is_end     = out_end_reg;

    `ASSERT_CLK(a_no_rw_overlap, !(rd_en && wr_en), "tag store read and write collide")
    `ASSERT_CLK(a_accept_to_exec, (s_valid && s_ready) |=> (state_reg == ST_EXEC),
        "accepted request did not enter execute")
    `ASSERT_CLK(a_clear_victim_zero, (state_reg == ST_CLEAR) |-> (victim_reg == '0),
        "victim pointer not zero during tag sweep")
    `ASSERT_CLK(a_result_from_exec, $rose(m_valid) |-> $past(state_reg == ST_EXEC),
        "result raised outside execute")

endmodule
